// File: design/stcg_pkg.sv
package stcg_pkg;

	localparam int GLYPH_COLUMNS = 5;
	localparam int GLYPH_ROWS    = 8;
	localparam int ROM_COLS      = 5;
	localparam int MAX_DISPLAY   = 64;
	localparam int PADDR_W       = 4;

	localparam logic [7:0] ROW_MASK = 8'((9'd1 << GLYPH_ROWS) - 9'd1);

	typedef enum logic [1:0] {
		REG_DISPLAY_WIDTH = 2'd0,
		REG_SCROLL_SHIFT  = 2'd1,
		REG_START_RIGHT   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [ROM_COLS-1:0][7:0] cols;
		logic [2:0]               width;
	} glyph_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic skip_whole;
		logic col_avail;
		logic last;
		logic slot_free;
	} sts_t;

	function automatic glyph_t glyph_entry(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4,
		input logic [3:0] w);
		glyph_t g;
		g.cols  = {c4, c3, c2, c1, c0};
		g.width = (w > 4'(GLYPH_COLUMNS)) ? 3'(GLYPH_COLUMNS) : w[2:0];
		return g;
	endfunction

	function automatic glyph_t font_glyph(input logic [6:0] code);
		glyph_t g;
		case (code)
			7'd0:   g = glyph_entry(8'h6C, 8'h82, 8'h82, 8'h6C, 8'h00, 4'd4);
			7'd1:   g = glyph_entry(8'h00, 8'h00, 8'h00, 8'h6C, 8'h00, 4'd4);
			7'd2:   g = glyph_entry(8'h60, 8'h92, 8'h92, 8'h0C, 8'h00, 4'd4);
			7'd3:   g = glyph_entry(8'h00, 8'h92, 8'h92, 8'h6C, 8'h00, 4'd4);
			7'd4:   g = glyph_entry(8'h0C, 8'h10, 8'h10, 8'h6C, 8'h00, 4'd4);
			7'd5:   g = glyph_entry(8'h0C, 8'h92, 8'h92, 8'h60, 8'h00, 4'd4);
			7'd6:   g = glyph_entry(8'h6C, 8'h92, 8'h92, 8'h60, 8'h80, 4'd5);
			7'd7:   g = glyph_entry(8'h00, 8'h02, 8'h02, 8'h6C, 8'h00, 4'd4);
			7'd8:   g = glyph_entry(8'h6C, 8'h92, 8'h92, 8'h6C, 8'h00, 4'd4);
			7'd9:   g = glyph_entry(8'h0C, 8'h92, 8'h92, 8'h6C, 8'h80, 4'd5);
			7'd10:  g = glyph_entry(8'h6C, 8'h12, 8'h12, 8'h6C, 8'h00, 4'd4);
			7'd11:  g = glyph_entry(8'h6C, 8'h90, 8'h90, 8'h60, 8'h00, 4'd4);
			7'd12:  g = glyph_entry(8'h6C, 8'h82, 8'h82, 8'h00, 8'h00, 4'd4);
			7'd13:  g = glyph_entry(8'h60, 8'h90, 8'h90, 8'h6C, 8'h00, 4'd4);
			7'd14:  g = glyph_entry(8'h6C, 8'h92, 8'h92, 8'h00, 8'h00, 4'd4);
			7'd15:  g = glyph_entry(8'h6C, 8'h12, 8'h12, 8'h00, 8'h00, 4'd4);
			7'd33:  g = glyph_entry(8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1);
			7'd34:  g = glyph_entry(8'h07, 8'h00, 8'h07, 8'h00, 8'h00, 4'd3);
			7'd35:  g = glyph_entry(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14, 4'd5);
			7'd36:  g = glyph_entry(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 4'd5);
			7'd37:  g = glyph_entry(8'h23, 8'h13, 8'h08, 8'h64, 8'h62, 4'd5);
			7'd38:  g = glyph_entry(8'h36, 8'h49, 8'h55, 8'h22, 8'h50, 4'd5);
			7'd39:  g = glyph_entry(8'h05, 8'h03, 8'h00, 8'h00, 8'h00, 4'd2);
			7'd40:  g = glyph_entry(8'h1C, 8'h22, 8'h41, 8'h00, 8'h00, 4'd3);
			7'd41:  g = glyph_entry(8'h41, 8'h22, 8'h1C, 8'h00, 8'h00, 4'd3);
			7'd42:  g = glyph_entry(8'h14, 8'h08, 8'h3E, 8'h08, 8'h14, 4'd5);
			7'd43:  g = glyph_entry(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08, 4'd5);
			7'd44:  g = glyph_entry(8'h50, 8'h30, 8'h00, 8'h00, 8'h00, 4'd2);
			7'd45:  g = glyph_entry(8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 4'd5);
			7'd46:  g = glyph_entry(8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 4'd2);
			7'd47:  g = glyph_entry(8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 4'd5);
			7'd48:  g = glyph_entry(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 4'd5);
			7'd49:  g = glyph_entry(8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 4'd3);
			7'd50:  g = glyph_entry(8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 4'd5);
			7'd51:  g = glyph_entry(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 4'd5);
			7'd52:  g = glyph_entry(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 4'd5);
			7'd53:  g = glyph_entry(8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 4'd5);
			7'd54:  g = glyph_entry(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 4'd5);
			7'd55:  g = glyph_entry(8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 4'd5);
			7'd56:  g = glyph_entry(8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 4'd5);
			7'd57:  g = glyph_entry(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 4'd5);
			7'd58:  g = glyph_entry(8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 4'd2);
			7'd59:  g = glyph_entry(8'h56, 8'h36, 8'h00, 8'h00, 8'h00, 4'd2);
			7'd60:  g = glyph_entry(8'h08, 8'h14, 8'h22, 8'h41, 8'h00, 4'd4);
			7'd61:  g = glyph_entry(8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 4'd5);
			7'd62:  g = glyph_entry(8'h41, 8'h22, 8'h14, 8'h08, 8'h00, 4'd4);
			7'd63:  g = glyph_entry(8'h02, 8'h01, 8'h51, 8'h09, 8'h06, 4'd5);
			7'd64:  g = glyph_entry(8'h30, 8'h49, 8'h79, 8'h41, 8'h3E, 4'd5);
			7'd65:  g = glyph_entry(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 4'd5);
			7'd66:  g = glyph_entry(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 4'd5);
			7'd67:  g = glyph_entry(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 4'd5);
			7'd68:  g = glyph_entry(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 4'd5);
			7'd69:  g = glyph_entry(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 4'd5);
			7'd70:  g = glyph_entry(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 4'd5);
			7'd71:  g = glyph_entry(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 4'd5);
			7'd72:  g = glyph_entry(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 4'd5);
			7'd73:  g = glyph_entry(8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 4'd3);
			7'd74:  g = glyph_entry(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01, 4'd5);
			7'd75:  g = glyph_entry(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 4'd5);
			7'd76:  g = glyph_entry(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 4'd5);
			7'd77:  g = glyph_entry(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 4'd5);
			7'd78:  g = glyph_entry(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 4'd5);
			7'd79:  g = glyph_entry(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 4'd5);
			7'd80:  g = glyph_entry(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 4'd5);
			7'd81:  g = glyph_entry(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 4'd5);
			7'd82:  g = glyph_entry(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46, 4'd5);
			7'd83:  g = glyph_entry(8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 4'd5);
			7'd84:  g = glyph_entry(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 4'd5);
			7'd85:  g = glyph_entry(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 4'd5);
			7'd86:  g = glyph_entry(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 4'd5);
			7'd87:  g = glyph_entry(8'h3F, 8'h40, 8'h30, 8'h40, 8'h3F, 4'd5);
			7'd88:  g = glyph_entry(8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 4'd5);
			7'd89:  g = glyph_entry(8'h07, 8'h08, 8'h70, 8'h08, 8'h07, 4'd5);
			7'd90:  g = glyph_entry(8'h61, 8'h51, 8'h49, 8'h45, 8'h43, 4'd5);
			7'd91:  g = glyph_entry(8'h7F, 8'h41, 8'h41, 8'h00, 8'h00, 4'd3);
			7'd92:  g = glyph_entry(8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 4'd5);
			7'd93:  g = glyph_entry(8'h41, 8'h41, 8'h7F, 8'h00, 8'h00, 4'd3);
			7'd94:  g = glyph_entry(8'h04, 8'h02, 8'h01, 8'h02, 8'h04, 4'd5);
			7'd95:  g = glyph_entry(8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 4'd5);
			7'd96:  g = glyph_entry(8'h01, 8'h02, 8'h04, 8'h00, 8'h00, 4'd3);
			7'd97:  g = glyph_entry(8'h20, 8'h54, 8'h54, 8'h54, 8'h78, 4'd5);
			7'd98:  g = glyph_entry(8'h7F, 8'h50, 8'h48, 8'h48, 8'h30, 4'd5);
			7'd99:  g = glyph_entry(8'h38, 8'h44, 8'h44, 8'h44, 8'h20, 4'd5);
			7'd100: g = glyph_entry(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F, 4'd5);
			7'd101: g = glyph_entry(8'h38, 8'h54, 8'h54, 8'h54, 8'h18, 4'd5);
			7'd102: g = glyph_entry(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02, 4'd5);
			7'd103: g = glyph_entry(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E, 4'd5);
			7'd104: g = glyph_entry(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78, 4'd5);
			7'd105: g = glyph_entry(8'h44, 8'h7D, 8'h40, 8'h00, 8'h00, 4'd3);
			7'd106: g = glyph_entry(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00, 4'd4);
			7'd107: g = glyph_entry(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00, 4'd4);
			7'd108: g = glyph_entry(8'h41, 8'h7F, 8'h40, 8'h00, 8'h00, 4'd3);
			7'd109: g = glyph_entry(8'h78, 8'h04, 8'h58, 8'h04, 8'h78, 4'd5);
			7'd110: g = glyph_entry(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78, 4'd5);
			7'd111: g = glyph_entry(8'h38, 8'h44, 8'h44, 8'h44, 8'h38, 4'd5);
			7'd112: g = glyph_entry(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08, 4'd5);
			7'd113: g = glyph_entry(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C, 4'd5);
			7'd114: g = glyph_entry(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08, 4'd5);
			7'd115: g = glyph_entry(8'h48, 8'h54, 8'h54, 8'h54, 8'h20, 4'd5);
			7'd116: g = glyph_entry(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20, 4'd5);
			7'd117: g = glyph_entry(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C, 4'd5);
			7'd118: g = glyph_entry(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C, 4'd5);
			7'd119: g = glyph_entry(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C, 4'd5);
			7'd120: g = glyph_entry(8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 4'd5);
			7'd121: g = glyph_entry(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C, 4'd5);
			7'd122: g = glyph_entry(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44, 4'd5);
			7'd123: g = glyph_entry(8'h08, 8'h36, 8'h41, 8'h00, 8'h00, 4'd3);
			7'd124: g = glyph_entry(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1);
			7'd125: g = glyph_entry(8'h41, 8'h36, 8'h08, 8'h00, 8'h00, 4'd3);
			7'd126: g = glyph_entry(8'h0C, 8'h02, 8'h0C, 8'h10, 8'h0C, 4'd5);
			7'd127: g = glyph_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0);
			// remaining codes (16 to 32): blank, full width
			default: g = glyph_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd5);
		endcase
		return g;
	endfunction

endpackage

// File: design/stcg_ctrl.sv
module stcg_ctrl import stcg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.skip_whole) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.col_avail) begin
					if (sts.slot_free) begin
						cmd.emit = 1'b1;
						if (sts.last) begin
							state_d = ST_IDLE;
						end
					end
				end else begin
					// nothing visible: just the gap column
					cmd.close = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/stcg_dp.sv
module stcg_dp import stcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] display_width,
	input  logic [6:0] scroll_shift,
	input  logic       start_right,
	input  logic [6:0] char_code,
	input  logic       first_of_text,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] column_index,
	output logic [7:0] column_bits,
	output logic       last_column
);

	logic [7:0] next_column_q;
	logic [6:0] skip_left_q;
	logic       skipping_q;
	logic [2:0] col_q;
	glyph_t     glyph_q;
	logic       out_valid_q;
	logic [5:0] column_index_q;
	logic [7:0] column_bits_q;
	logic       last_column_q;

	logic [6:0] width_eff;
	logic [7:0] start_col;
	glyph_t     glyph_in;
	logic       eff_skipping;
	logic [6:0] eff_skip;
	logic [7:0] eff_next;
	logic [2:0] col_next;

	assign width_eff = (display_width > 7'(MAX_DISPLAY)) ? 7'(MAX_DISPLAY) : display_width;
	assign start_col = (start_right && (scroll_shift < width_eff)) ?
		{1'b0, width_eff - scroll_shift} : 8'd0;

	assign glyph_in     = font_glyph(char_code);
	assign eff_skipping = first_of_text | skipping_q;
	assign eff_skip     = first_of_text ? scroll_shift : skip_left_q;
	assign eff_next     = first_of_text ? start_col : next_column_q;
	assign col_next     = col_q + 3'd1;

	assign sts.skip_whole = eff_skipping && (eff_skip >= {4'd0, glyph_in.width});
	assign sts.col_avail  = (col_q < glyph_q.width) && (next_column_q < {1'b0, width_eff});
	assign sts.last       = (col_next >= glyph_q.width) ||
		((next_column_q + 8'd1) >= {1'b0, width_eff});
	assign sts.slot_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_column_q <= 8'd0;
			skip_left_q   <= 7'd0;
			skipping_q    <= 1'b1;
			col_q         <= 3'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				next_column_q <= eff_next;
				if (sts.skip_whole) begin
					skip_left_q <= eff_skip - {4'd0, glyph_in.width};
					skipping_q  <= 1'b1;
				end else if (eff_skipping) begin
					col_q       <= eff_skip[2:0];
					skip_left_q <= 7'd0;
					skipping_q  <= 1'b0;
				end else begin
					col_q <= 3'd0;
				end
			end else if (cmd.emit) begin
				col_q         <= col_next;
				// last column also steps over the gap
				next_column_q <= next_column_q + (sts.last ? 8'd2 : 8'd1);
			end else if (cmd.close) begin
				if (next_column_q != 8'hFF) begin
					next_column_q <= next_column_q + 8'd1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q <= glyph_in;
		end
		if (cmd.emit) begin
			column_index_q <= next_column_q[5:0];
			column_bits_q  <= glyph_q.cols[col_q] & ROW_MASK;
			last_column_q  <= sts.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = column_index_q;
	assign column_bits  = column_bits_q;
	assign last_column  = last_column_q;

endmodule

// File: design/scrolling_text_column_generator.sv
// channel  | handshake                      | payload
// cfg      | psel penable pwrite pready     | paddr pwdata prdata
// in       | in_valid in_ready              | char_code first_of_text
// out      | out_valid out_ready            | column_index column_bits last_column
//
// A character is taken in from the idle state, then its visible columns are emitted in turn;
// a character that enters the emit state with no visible column only steps over its gap.
// When not stalled, the sequencer emits one glyph column per cycle into a single output
// register. A stalled output register holds the sequencer; the next character is taken
// while the final column of the previous one still waits.
// Reset clears the column position and skip, and loads the register defaults.
module scrolling_text_column_generator import stcg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [6:0]         char_code,
	input  logic               first_of_text,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         column_index,
	output logic [7:0]         column_bits,
	output logic               last_column
);

	logic [6:0] display_width_q;
	logic [6:0] scroll_shift_q;
	logic       start_right_q;
	logic       wr_en;
	reg_idx_t   reg_sel;
	cmd_t       cmd;
	sts_t       sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_width_q <= 7'd32;
			scroll_shift_q  <= 7'd0;
			start_right_q   <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DISPLAY_WIDTH: display_width_q <= pwdata[6:0];
				REG_SCROLL_SHIFT:  scroll_shift_q  <= pwdata[6:0];
				REG_START_RIGHT:   start_right_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DISPLAY_WIDTH: prdata = {25'd0, display_width_q};
			REG_SCROLL_SHIFT:  prdata = {25'd0, scroll_shift_q};
			REG_START_RIGHT:   prdata = {31'd0, start_right_q};
			default:           prdata = 32'd0;
		endcase
	end

	stcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stcg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.display_width (display_width_q),
		.scroll_shift  (scroll_shift_q),
		.start_right   (start_right_q),
		.char_code     (char_code),
		.first_of_text (first_of_text),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.column_index  (column_index),
		.column_bits   (column_bits),
		.last_column   (last_column)
	);

endmodule

// File: design/stcg_checker.sv
module stcg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] column_index,
	input logic [7:0] column_bits,
	input logic       last_column
);

	// stalled transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column_index) &&
		$stable(column_bits) && $stable(last_column))
		else $error("output changed while stalled");

	// mid-glyph column pending: no new character taken
	a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_column |-> !in_ready)
		else $error("input ready in the middle of a glyph");

	// columns of one glyph follow back to back on adjacent display columns
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_column |=>
		out_valid && (column_index == $past(column_index) + 6'd1))
		else $error("glyph columns not contiguous");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind scrolling_text_column_generator stcg_checker u_stcg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.column_index (column_index),
	.column_bits  (column_bits),
	.last_column  (last_column)
);
